FILE: hdl/raster_thinning_subiteration_unit_macros.svh
// assertion macros for the raster thinning sub-cycle unit
// expects clk and rst_n in the scope of each use
`ifndef RASTER_THINNING_SUBITERATION_UNIT_MACROS_SVH
`define RASTER_THINNING_SUBITERATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RTS_ASSERT_IMPL(label, ante, cons)
`define RTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hdl/rts_pkg.sv
// shared types, constants and deletion tables of the thinning sub-cycle unit
// no dependencies
package rts_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int FW_W  = 11;
  localparam int FH_W  = 16;
  localparam int CNT_W = 26;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_SUB_STEP     = 2'd2;

  localparam logic [FW_W-1:0] FW_RST = 11'd640;
  localparam logic [FH_W-1:0] FH_RST = 16'd480;
  localparam cnt_t            CNT_MAX = '1;

  // neighbour code: bit0 E, bit1 NE, bit2 N, bit3 NW, bit4 W, bit5 SW, bit6 S, bit7 SE
  function automatic logic deletable(input logic second, input logic [7:0] code);
    logic hit;
    if (second) begin
      hit = code inside {8'd0, 8'd3, 8'd5, 8'd6, 8'd7, 8'd12, 8'd14, 8'd15, 8'd20, 8'd22,
                         8'd24, 8'd28, 8'd30, 8'd31, 8'd48, 8'd52, 8'd54, 8'd56, 8'd60,
                         8'd62, 8'd63, 8'd65, 8'd80, 8'd88, 8'd96, 8'd112, 8'd120, 8'd129,
                         8'd131, 8'd135, 8'd143, 8'd159, 8'd191, 8'd192, 8'd193, 8'd195,
                         8'd199, 8'd207, 8'd208, 8'd216, 8'd224, 8'd225, 8'd227, 8'd231,
                         8'd239, 8'd240, 8'd248};
    end else begin
      hit = code inside {8'd0, 8'd3, 8'd6, 8'd7, 8'd12, 8'd13, 8'd14, 8'd15, 8'd24, 8'd28,
                         8'd30, 8'd48, 8'd56, 8'd60, 8'd62, 8'd65, 8'd67, 8'd80, 8'd96,
                         8'd97, 8'd99, 8'd112, 8'd120, 8'd124, 8'd126, 8'd129, 8'd131,
                         8'd133, 8'd135, 8'd141, 8'd143, 8'd192, 8'd193, 8'd195, 8'd224,
                         8'd225, 8'd227, 8'd240, 8'd241, 8'd243, 8'd248, 8'd249, 8'd251,
                         8'd252, 8'd254};
    end
    return hit;
  endfunction

endpackage

FILE: hdl/rts_pix_in_if.sv
// input pixel channel: valid/ready handshake with one binary pixel
// no dependencies
interface rts_pix_in_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

FILE: hdl/rts_pix_out_if.sv
// result channel: valid/ready handshake with thinned pixel, flags and deletion count
// depends on rts_pkg
interface rts_pix_out_if;
  import rts_pkg::*;

  logic valid;
  logic ready;
  logic pixel_out;
  logic was_deleted;
  logic frame_last;
  cnt_t deleted_total;

  modport source (output valid, output pixel_out, output was_deleted, output frame_last,
                  output deleted_total, input ready);
  modport sink   (input valid, input pixel_out, input was_deleted, input frame_last,
                  input deleted_total, output ready);
endinterface

FILE: hdl/raster_thinning_subiteration_unit.sv
// thinning sub-cycle unit: line buffers, 3x3 window, table decode, result register
// depends on rts_pkg, rts_pix_in_if, rts_pix_out_if, rts_ram and the assertion macros
// throughput: one word per cycle if out_ch keeps up; two row buffers share one ram, read at accept
// the word for (r+1,c+1) completes pixel (r,c); its result goes through stage 1 to the result register
// reset (rst_n, synchronous, active low): counters, window, fill count and valid flags clear,
// registers return to 640 x 480, first table; no clearing pass, a fill count masks the ram
`include "raster_thinning_subiteration_unit_macros.svh"

module raster_thinning_subiteration_unit #(
  parameter int unsigned MAX_WIDTH = rts_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  rts_pkg::cfg_idx_t         cfg_index,
  input  logic [rts_pkg::CFG_W-1:0] cfg_wdata,
  rts_pix_in_if.sink                in_ch,
  rts_pix_out_if.source             out_ch
);
  import rts_pkg::*;

  // column counter width and the width used to compare against the frame width
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam logic [WW-1:0] MAXW     = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] MINW     = WW'(3);
  localparam logic [CW:0]   FILL_MAX = (CW + 1)'(MAX_WIDTH);

  // configuration registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            sub_step_r;

  // raster position of the next arriving word
  logic [CW-1:0]   col_r, col_nxt;
  logic [FH_W-1:0] row_r, row_nxt;
  // number of ram entries written since reset (always columns 0..fill-1)
  logic [CW:0]     fill_r, fill_nxt;

  // stage 1: accepted word waiting for its ram read data
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_px_r;
  logic            s1_res_r;
  logic            s1_last_r;
  logic            s1_clear_r;
  logic            s1_fresh_r;
  logic [CW-1:0]   s1_col_r;

  // moving 3x3 window: three column triples, bit0 top, bit1 middle, bit2 bottom
  logic [8:0]      window_r, window_nxt;
  cnt_t            cnt_r, cnt_nxt, cnt_base;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic            out_px_r;
  logic            out_del_r;
  logic            out_last_r;
  cnt_t            out_tot_r;

  logic            in_acc;
  logic            in_rdy;
  logic            s1_go;
  logic [WW-1:0]   eff_w;
  logic [WW-1:0]   fw_ext;
  logic [FH_W-1:0] eff_h;
  logic [WW-1:0]   col_ext;
  logic [WW-1:0]   col_inc;
  logic [FH_W:0]   row_inc;
  logic            col_wrap;
  logic            row_wrap;
  logic            fresh;
  logic [1:0]      ram_rdata;
  logic            up_bit;
  logic            mid_bit;
  logic            centre;
  logic [7:0]      code;
  logic            del;

  // ---------------------------------------------------------------------------
  // configuration port, effective frame size
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RST;
      frame_height_r <= FH_RST;
      sub_step_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        REG_SUB_STEP:     sub_step_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // width clamps to 3..MAX_WIDTH, height to at least 3
  always_comb begin
    fw_ext = WW'(frame_width_r);
    if (fw_ext < MINW) begin
      eff_w = MINW;
    end else if (fw_ext > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (frame_height_r < FH_W'(3)) ? FH_W'(3) : frame_height_r;
  end

  // ---------------------------------------------------------------------------
  // handshake: stage 1 moves on when the result register is free or being taken
  // ---------------------------------------------------------------------------
  assign s1_go        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_rdy       = !s1_valid_r || s1_go;
  assign in_ch.ready  = in_rdy;
  assign in_acc       = in_ch.valid && in_rdy;

  // ---------------------------------------------------------------------------
  // raster position; a counter beyond a newly written bound wraps after this word
  // ---------------------------------------------------------------------------
  always_comb begin
    col_ext  = WW'(col_r);
    col_inc  = col_ext + WW'(1);
    row_inc  = {1'b0, row_r} + (FH_W + 1)'(1);
    col_wrap = (col_inc >= eff_w);
    row_wrap = (row_inc >= {1'b0, eff_h});
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : row_inc[FH_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = (row_r >= eff_h) ? '0 : row_r;
    end
    // columns are visited contiguously from zero, so entry col is written iff col < fill
    fresh    = ({1'b0, col_r} < fill_r);
    fill_nxt = fresh ? fill_r : fill_r + (CW + 1)'(1);
  end

  // ---------------------------------------------------------------------------
  // row buffers: bit0 upper row, bit1 centre row, one entry per column
  // read when the word is accepted, written when it leaves stage 1
  // ---------------------------------------------------------------------------
  rts_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata ({s1_px_r, mid_bit}),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // never-written entries read as background
  assign up_bit  = s1_fresh_r & ram_rdata[0];
  assign mid_bit = s1_fresh_r & ram_rdata[1];

  // ---------------------------------------------------------------------------
  // window shift and neighbour decode
  // ---------------------------------------------------------------------------
  always_comb begin
    window_nxt = {s1_px_r, mid_bit, up_bit, window_r[8:3]};
    centre     = window_nxt[4];
    code       = {window_nxt[8],   // SE
                  window_nxt[5],   // S
                  window_nxt[2],   // SW
                  window_nxt[1],   // W
                  window_nxt[0],   // NW
                  window_nxt[3],   // N
                  window_nxt[6],   // NE
                  window_nxt[7]};  // E
    // only interior pixels can be deleted and counted
    del        = s1_res_r && centre && deletable(sub_step_r, code);
    // frame start clears the count before this word's deletion is added
    cnt_base   = s1_clear_r ? '0 : cnt_r;
    cnt_nxt    = (del && (cnt_base != CNT_MAX)) ? cnt_base + cnt_t'(1) : cnt_base;
  end

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    if (s1_go && s1_res_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      window_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        fill_r <= fill_nxt;
      end
      if (s1_go) begin
        window_r <= window_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r    <= in_ch.pixel_in;
      s1_res_r   <= (row_r >= FH_W'(2)) && (col_r >= CW'(2));
      s1_last_r  <= (row_r == eff_h - FH_W'(1)) && (col_ext == eff_w - WW'(1));
      s1_clear_r <= (row_r == '0) && (col_r == '0);
      s1_fresh_r <= fresh;
      s1_col_r   <= col_r;
    end
    if (s1_go && s1_res_r) begin
      out_px_r   <= centre && !del;
      out_del_r  <= del;
      out_last_r <= s1_last_r;
      out_tot_r  <= cnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_out     = out_px_r;
  assign out_ch.was_deleted   = out_del_r;
  assign out_ch.frame_last    = out_last_r;
  assign out_ch.deleted_total = out_tot_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `RTS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FILL_MAX)
  `RTS_ASSERT_IMPL(a_stall_blocks_input, s1_valid_r && !s1_go, !in_rdy)
  `RTS_ASSERT_IMPL(a_del_clears_pixel, out_valid_r && out_del_r, !out_px_r)
  `RTS_ASSERT_NEXT(a_cnt_monotonic, s1_go && !s1_clear_r, cnt_r >= $past(cnt_r))
  `RTS_ASSERT_NEXT(a_result_loads, s1_go && s1_res_r, out_valid_r)

endmodule

FILE: hdl/rts_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module rts_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/tb_top.sv
// self-checking bench for the raster thinning sub-cycle unit: streams binary frames,
// predicts every thinned pixel word and compares each result word field by field
// depends on rts_pkg, rts_pix_in_if, rts_pix_out_if and raster_thinning_subiteration_unit
module tb_top;
  import rts_pkg::*;

  localparam int unsigned MAX_W         = MAX_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS  = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  // extra wait after the last expected result word, as margin for the pipe
  localparam int unsigned SETTLE_CYCLES = 4;
  // index with no register behind it
  localparam cfg_idx_t    REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic pixel_out;
    logic was_deleted;
    logic frame_last;
    cnt_t deleted_total;
  } thin_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rts_pix_in_if  in_ch ();
  rts_pix_out_if out_ch ();

  raster_thinning_subiteration_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow copy of the block: registers, two row stores, 3x3 window, position, count
  logic [FW_W-1:0] shadow_width;
  logic [FH_W-1:0] shadow_height;
  logic            shadow_second;
  bit              prev_row [0:MAX_W-1];
  bit              cur_row  [0:MAX_W-1];
  logic [8:0]      win3x3;
  int unsigned     next_col;
  int unsigned     next_row;
  int unsigned     frame_deletions;

  thin_result_t    pending_results [$];
  int unsigned     mismatches;
  int unsigned     results_checked;
  int unsigned     pixels_sent;
  int unsigned     cycles;
  bit              steady;

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure: ready drawn low with a 30 percent chance, never while steady
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 30);
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatches++;
    $display("mismatch at cycle %0d: %0s, expected %0d, got %0d", cycles, what, want, got);
  endtask

  // effective geometry: width clamps to 3..MAX_W, height has a floor of 3
  function automatic int unsigned active_width();
    if (shadow_width < 3) return 3;
    if (shadow_width > MAX_W) return MAX_W;
    return shadow_width;
  endfunction

  function automatic int unsigned active_height();
    return (shadow_height < 3) ? 3 : shadow_height;
  endfunction

  // code bits: 0 E, 1 NE, 2 N, 3 NW, 4 W, 5 SW, 6 S, 7 SE
  function automatic bit thinning_deletes(input bit second, input logic [7:0] code);
    bit hit;
    hit = 1'b0;
    if (second) begin
      case (code)
        8'd0, 8'd3, 8'd5, 8'd6, 8'd7, 8'd12, 8'd14, 8'd15, 8'd20, 8'd22, 8'd24, 8'd28,
        8'd30, 8'd31, 8'd48, 8'd52, 8'd54, 8'd56, 8'd60, 8'd62, 8'd63, 8'd65, 8'd80,
        8'd88, 8'd96, 8'd112, 8'd120, 8'd129, 8'd131, 8'd135, 8'd143, 8'd159, 8'd191,
        8'd192, 8'd193, 8'd195, 8'd199, 8'd207, 8'd208, 8'd216, 8'd224, 8'd225, 8'd227,
        8'd231, 8'd239, 8'd240, 8'd248: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end else begin
      case (code)
        8'd0, 8'd3, 8'd6, 8'd7, 8'd12, 8'd13, 8'd14, 8'd15, 8'd24, 8'd28, 8'd30, 8'd48,
        8'd56, 8'd60, 8'd62, 8'd65, 8'd67, 8'd80, 8'd96, 8'd97, 8'd99, 8'd112, 8'd120,
        8'd124, 8'd126, 8'd129, 8'd131, 8'd133, 8'd135, 8'd141, 8'd143, 8'd192, 8'd193,
        8'd195, 8'd224, 8'd225, 8'd227, 8'd240, 8'd241, 8'd243, 8'd248, 8'd249, 8'd251,
        8'd252, 8'd254: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // advance the shadow by one accepted pixel word, queue the thinned word it completes
  task automatic thin_pixel(input bit px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    bit           up;
    bit           mid;
    logic [7:0]   code;
    bit           centre;
    bit           del;
    thin_result_t res;
    w = active_width();
    h = active_height();
    c = next_col;
    r = next_row;
    up = 1'b0;
    mid = 1'b0;
    // frame start clears the running count
    if (r == 0 && c == 0) frame_deletions = 0;
    if (c < MAX_W) begin
      up = prev_row[c];
      mid = cur_row[c];
      prev_row[c] = mid;
      cur_row[c] = px;
    end
    // newest column enters at the top, each column is {bottom, middle, top}
    win3x3 = {px, mid, up, win3x3[8:3]};
    if (r >= 2 && c >= 2) begin
      centre = win3x3[4];
      code = {win3x3[8], win3x3[5], win3x3[2], win3x3[1],
              win3x3[0], win3x3[3], win3x3[6], win3x3[7]};
      del = centre && thinning_deletes(shadow_second, code);
      // count saturates at the top of its range
      if (del && frame_deletions < CNT_MAX) frame_deletions++;
      res.pixel_out = centre && !del;
      res.was_deleted = del;
      res.frame_last = (r == h - 1) && (c == w - 1);
      res.deleted_total = frame_deletions[CNT_W-1:0];
      pending_results.push_back(res);
    end
    // a position beyond a freshly shrunk bound wraps after this pixel
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
    if (next_row >= h) next_row = 0;
  endtask

  // every accepted result word is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    thin_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected", 0, 1);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_ch.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", want.pixel_out, out_ch.pixel_out);
        if (out_ch.was_deleted !== want.was_deleted)
          report_mismatch("was_deleted", want.was_deleted, out_ch.was_deleted);
        if (out_ch.frame_last !== want.frame_last)
          report_mismatch("frame_last", want.frame_last, out_ch.frame_last);
        if (out_ch.deleted_total !== want.deleted_total)
          report_mismatch("deleted_total", want.deleted_total, out_ch.deleted_total);
      end
    end
  end

  // one pixel word on the input channel, with random idle cycles ahead of it
  task automatic send_pixel(input bit px);
    while (!steady && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_in <= px;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    thin_pixel(px);
  endtask

  // stop sending, wait for every expected word, then let the pipe run dry
  task automatic settle_results();
    int unsigned waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch("result words never arrived", pending_results.size(), 0);
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  shadow_width = data[FW_W-1:0];
      REG_FRAME_HEIGHT: shadow_height = data[FH_W-1:0];
      REG_SUB_STEP:     shadow_second = data[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned density);
    int unsigned n;
    n = active_width() * active_height();
    repeat (n) send_pixel($urandom_range(99) < density);
  endtask

  // fill out the current frame so the next word lands on row 0, column 0
  task automatic align_frame();
    while (next_col != 0 || next_row != 0) send_pixel(1'($urandom_range(1)));
  endtask

  // 3x3 frame whose centre has the given neighbour code
  task automatic send_window(input bit centre, input logic [7:0] code);
    send_pixel(code[3]); send_pixel(code[2]); send_pixel(code[1]);
    send_pixel(code[4]); send_pixel(centre);  send_pixel(code[0]);
    send_pixel(code[5]); send_pixel(code[6]); send_pixel(code[7]);
  endtask

  // reset width 640 for the first row, then a width word above the limit clamps
  // to the widest row; the row runs on past column 639 and wraps after column 1023
  task automatic test_reset_geometry();
    repeat (639) send_pixel(1'($urandom_range(1)));
    settle_results();
    write_register(REG_FRAME_WIDTH, 16'hFFFF);
    // long stretch with no idling on either side
    steady = 1'b1;
    repeat (MAX_W - 639 + 4) send_pixel(1'($urandom_range(1)));
    steady = 1'b0;
    settle_results();
  endtask

  // writes in the middle of a frame: counters beyond the new bound wrap after one pixel
  task automatic test_midframe_write();
    // upper data bits above the width field are dropped
    write_register(REG_FRAME_WIDTH, 16'hF803);
    send_pixel(1'b1);
    // one more row of three takes the position to row 3
    repeat (3) send_pixel(1'($urandom_range(1)));
    settle_results();
    // height below 3 acts as 3, row 3 is then out of range
    write_register(REG_FRAME_HEIGHT, 16'd0);
    align_frame();
    settle_results();
  endtask

  // single-window frames: both tables, a set centre and a background centre
  task automatic test_single_windows();
    write_register(REG_FRAME_WIDTH, 16'd3);
    write_register(REG_FRAME_HEIGHT, 16'd3);
    write_register(REG_SUB_STEP, 16'd0);
    // east and north set: kept by the first table
    send_window(1'b1, 8'd5);
    // background centre with all neighbours set
    send_window(1'b0, 8'hFF);
    settle_results();
    write_register(REG_SUB_STEP, 16'd1);
    // same code is deleted by the second table
    send_window(1'b1, 8'd5);
    settle_results();
  endtask

  // clamped and extreme register values
  task automatic test_size_extremes();
    write_register(REG_FRAME_WIDTH, 16'd0);
    write_register(REG_FRAME_HEIGHT, 16'd2);
    // only bit 0 of the step word counts
    write_register(REG_SUB_STEP, 16'hFFFE);
    write_register(REG_UNUSED, 16'hFFFF);
    send_frame(100);
    settle_results();
    // wider frame, step word with more than bit 0 set
    write_register(REG_FRAME_WIDTH, 16'd40);
    write_register(REG_FRAME_HEIGHT, 16'd3);
    write_register(REG_SUB_STEP, 16'h0003);
    send_frame(60);
    settle_results();
    // tallest frame, cut short by a height write part way down
    write_register(REG_FRAME_WIDTH, 16'd3);
    write_register(REG_FRAME_HEIGHT, 16'hFFFF);
    repeat (30) send_pixel($urandom_range(99) < 70);
    settle_results();
    write_register(REG_FRAME_HEIGHT, 16'd5);
    align_frame();
    settle_results();
  endtask

  function automatic logic [CFG_W-1:0] random_width_word();
    logic [FW_W-1:0]       w;
    logic [CFG_W-FW_W-1:0] junk;
    int unsigned           pick;
    pick = $urandom_range(99);
    junk = (CFG_W - FW_W)'($urandom_range(31));
    if (pick < 80) w = FW_W'($urandom_range(10, 3));
    else if (pick < 95) w = FW_W'($urandom_range(24, 11));
    else w = FW_W'($urandom_range(2, 0));
    return {junk, w};
  endfunction

  function automatic logic [CFG_W-1:0] random_height_word();
    return CFG_W'(($urandom_range(99) < 90) ? $urandom_range(10, 3) : $urandom_range(2, 0));
  endfunction

  task automatic write_random_setting();
    write_register(REG_FRAME_WIDTH, random_width_word());
    write_register(REG_FRAME_HEIGHT, random_height_word());
    write_register(REG_SUB_STEP, CFG_W'($urandom_range(16'hFFFF)));
  endtask

  // random frames: mostly whole frames under fresh settings, some back to back,
  // some cut short by a mid-frame rewrite
  task automatic test_random_frames();
    int unsigned start;
    int unsigned done;
    int unsigned pick;
    int unsigned density;
    int unsigned n;
    start = pixels_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // middle third runs with no idling on either side
      steady = (done > RANDOM_ITEMS / 3) && (done < 2 * RANDOM_ITEMS / 3);
      pick = $urandom_range(99);
      case ($urandom_range(4))
        0: density = 10;
        1: density = 40;
        2: density = 60;
        3: density = 85;
        default: density = 100;
      endcase
      if (pick < 70) begin
        settle_results();
        write_random_setting();
        send_frame(density);
      end else if (pick < 85) begin
        send_frame(density);
      end else begin
        n = $urandom_range(active_width() * active_height() - 1, 1);
        repeat (n) send_pixel($urandom_range(99) < density);
        settle_results();
        write_random_setting();
        align_frame();
      end
      done = pixels_sent - start;
    end
    steady = 1'b0;
    settle_results();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel_in = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_wdata = '0;
    steady = 1'b0;
    mismatches = 0;
    results_checked = 0;
    pixels_sent = 0;
    cycles = 0;
    // shadow state after reset
    shadow_width = FW_RST;
    shadow_height = FH_RST;
    shadow_second = 1'b0;
    foreach (prev_row[i]) prev_row[i] = 1'b0;
    foreach (cur_row[i]) cur_row[i] = 1'b0;
    win3x3 = '0;
    next_col = 0;
    next_row = 0;
    frame_deletions = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_midframe_write();
    test_single_windows();
    test_size_extremes();
    test_random_frames();

    $display("%0d pixel words in, %0d thinned words checked", pixels_sent, results_checked);
    $display("frames 3 to 1024 wide, clamped sizes, mid-frame rewrites, both tables");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
